// ===== hdl/rbc_pkg.sv =====
package rbc_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int SIDE_N      = MAX_SIDE + 1;
	localparam int TABLE_DEPTH = SIDE_N * SIDE_N;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COORD_W     = 9;
	localparam int VALUE_W     = 17;
	// signed sum of four table entries
	localparam int COUNT_W     = VALUE_W + 2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// box coordinate slots
	localparam logic [1:0] IDX_X_LO = 2'd0;
	localparam logic [1:0] IDX_X_HI = 2'd1;
	localparam logic [1:0] IDX_Y_LO = 2'd2;
	localparam logic [1:0] IDX_Y_HI = 2'd3;

	typedef enum logic [1:0] {
		ACT_IGNORE  = 2'd0,
		ACT_INCLUDE = 2'd1,
		ACT_BISECT  = 2'd2
	} rbc_action_t;

	// bit 0 selects the dimension, bit 1 the upper border
	typedef enum logic [1:0] {
		BORDER_X_LO = 2'd0,
		BORDER_Y_LO = 2'd1,
		BORDER_X_HI = 2'd2,
		BORDER_Y_HI = 2'd3
	} rbc_border_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RD,
		ST_EVAL,
		ST_LOAD,
		ST_STEP,
		ST_DONE
	} rbc_state_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [VALUE_W-1:0] wdata;
	} rbc_ram_req_t;

	typedef struct packed {
		rbc_action_t        action;
		logic               empty;
		logic [COORD_W-1:0] x_lo;
		logic [COORD_W-1:0] x_hi;
		logic [COORD_W-1:0] y_lo;
		logic [COORD_W-1:0] y_hi;
	} rbc_result_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
		return (v > COORD_W'(MAX_SIDE)) ? COORD_W'(MAX_SIDE) : v;
	endfunction

	function automatic logic [ADDR_W-1:0] table_addr(input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col);
		logic [ADDR_W-1:0] r_ext;
		logic [ADDR_W-1:0] c_ext;
		r_ext = ADDR_W'(row);
		c_ext = ADDR_W'(col);
		return r_ext * ADDR_W'(SIDE_N) + c_ext;
	endfunction

endpackage

// ===== hdl/rbc_if.sv =====
interface rbc_req_if;
	import rbc_pkg::*;

	logic                valid;
	logic                ready;
	logic                kind;
	logic [COORD_W-1:0]  table_row;
	logic [COORD_W-1:0]  table_col;
	logic [VALUE_W-1:0]  table_value;
	logic [COORD_W-1:0]  x_lo;
	logic [COORD_W-1:0]  x_hi;
	logic [COORD_W-1:0]  y_lo;
	logic [COORD_W-1:0]  y_hi;
	logic                box_is_empty;

	modport source (
		output valid, kind, table_row, table_col, table_value,
		output x_lo, x_hi, y_lo, y_hi, box_is_empty,
		input  ready
	);
	modport sink (
		input  valid, kind, table_row, table_col, table_value,
		input  x_lo, x_hi, y_lo, y_hi, box_is_empty,
		output ready
	);
endinterface

interface rbc_rsp_if;
	import rbc_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic                out_empty;
	logic [COORD_W-1:0]  out_x_lo;
	logic [COORD_W-1:0]  out_x_hi;
	logic [COORD_W-1:0]  out_y_lo;
	logic [COORD_W-1:0]  out_y_hi;

	modport source (
		output valid, action, out_empty, out_x_lo, out_x_hi, out_y_lo, out_y_hi,
		input  ready
	);
	modport sink (
		input  valid, action, out_empty, out_x_lo, out_x_hi, out_y_lo, out_y_hi,
		output ready
	);
endinterface

// ===== hdl/rbc_area_ram.sv =====
module rbc_area_ram #(
	parameter int DEPTH  = 66049,
	parameter int WIDTH  = 17,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/rbc_seq.sv =====
module rbc_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	rbc_req_if.sink                        req,
	output rbc_pkg::rbc_result_t           res,
	output logic                           res_valid,
	input  logic                           res_take,
	output rbc_pkg::rbc_ram_req_t          ram_req,
	input  logic [rbc_pkg::VALUE_W-1:0]    ram_rdata
);
	import rbc_pkg::*;

	rbc_state_t             state_q, state_d;

	// control
	rbc_border_t            border_q;
	logic                   tighten_q;
	logic [2:0]             cnt_q;

	// payload
	logic [COORD_W-1:0]     box_q  [4];
	logic [COORD_W-1:0]     cand_q [4];
	logic [COORD_W-1:0]     w_lo_q;
	logic [COORD_W-1:0]     w_hi_q;
	logic [COORD_W-1:0]     mid_q;
	logic signed [COUNT_W-1:0] acc_q;
	logic [VALUE_W-1:0]     area_q;
	logic [COORD_W-1:0]     wr_row_q;
	logic [COORD_W-1:0]     wr_col_q;
	logic [VALUE_W-1:0]     wr_val_q;
	logic                   wr_ok_q;
	rbc_action_t            act_q;
	logic                   empty_q;

	logic                   accept;
	logic [COORD_W-1:0]     s_x_lo, s_x_hi, s_y_lo, s_y_hi;
	logic                   bad_box;
	logic [1:0]             lo_idx, hi_idx;
	logic                   upper;
	logic [COORD_W:0]       mid_sum;
	logic [COORD_W-1:0]     mid;
	logic                   can_split;
	logic [COORD_W-1:0]     cand_d [4];
	logic [COORD_W-1:0]     rd_row, rd_col;
	logic                   add_pos;
	logic signed [COUNT_W-1:0] rd_ext;
	logic signed [COUNT_W-1:0] acc_next;
	logic [COORD_W-1:0]     dx, dy;
	logic [2*COORD_W-1:0]   area_full;
	logic                   zero;
	logic                   full;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign s_x_lo  = sat_coord(req.x_lo);
	assign s_x_hi  = sat_coord(req.x_hi);
	assign s_y_lo  = sat_coord(req.y_lo);
	assign s_y_hi  = sat_coord(req.y_hi);
	assign bad_box = req.box_is_empty || (s_x_lo > s_x_hi) || (s_y_lo > s_y_hi);

	assign lo_idx    = {border_q[0], 1'b0};
	assign hi_idx    = {border_q[0], 1'b1};
	assign upper     = border_q[1];
	assign mid_sum   = {1'b0, w_lo_q} + {1'b0, w_hi_q};
	assign mid       = mid_sum[COORD_W:1];
	assign can_split = {1'b0, w_hi_q} > ({1'b0, w_lo_q} + (COORD_W+1)'(1));

	// half box probed by the next white count
	always_comb begin
		cand_d         = box_q;
		cand_d[lo_idx] = upper ? mid : w_lo_q;
		cand_d[hi_idx] = upper ? w_hi_q : mid;
	end

	// corner order: (yhi,xhi) + , (ylo,xhi) - , (yhi,xlo) - , (ylo,xlo) +
	assign rd_row = cnt_q[0] ? cand_q[IDX_Y_LO] : cand_q[IDX_Y_HI];
	assign rd_col = cnt_q[1] ? cand_q[IDX_X_LO] : cand_q[IDX_X_HI];

	assign add_pos  = (cnt_q == 3'd1) || (cnt_q == 3'd4);
	assign rd_ext   = $signed({2'b00, ram_rdata});
	assign acc_next = add_pos ? (acc_q + rd_ext) : (acc_q - rd_ext);

	assign dx        = box_q[IDX_X_HI] - box_q[IDX_X_LO];
	assign dy        = box_q[IDX_Y_HI] - box_q[IDX_Y_LO];
	assign area_full = {COORD_W'(0), dx} * {COORD_W'(0), dy};

	assign zero = (acc_q == '0);
	assign full = (acc_q == $signed({2'b00, area_q}));

	always_comb begin
		ram_req.we    = (state_q == ST_WRITE) && wr_ok_q;
		ram_req.wdata = wr_val_q;
		ram_req.addr  = (state_q == ST_WRITE) ? table_addr(wr_row_q, wr_col_q)
		                                      : table_addr(rd_row, rd_col);
	end

	assign res_valid  = (state_q == ST_DONE);
	assign res.action = act_q;
	assign res.empty  = empty_q;
	assign res.x_lo   = empty_q ? '0 : box_q[IDX_X_LO];
	assign res.x_hi   = empty_q ? '0 : box_q[IDX_X_HI];
	assign res.y_lo   = empty_q ? '0 : box_q[IDX_Y_LO];
	assign res.y_hi   = empty_q ? '0 : box_q[IDX_Y_HI];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_WRITE) begin
						state_d = ST_WRITE;
					end else if (bad_box) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_RD: begin
				if (cnt_q == 3'd4) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (tighten_q) begin
					state_d = ST_STEP;
				end else if (zero || full) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_STEP;
			ST_STEP: begin
				if (can_split) begin
					state_d = ST_RD;
				end else if (border_q == BORDER_Y_HI) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q  <= BORDER_X_LO;
			tighten_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tighten_q <= 1'b0;
						cnt_q     <= '0;
					end
				end
				ST_RD: cnt_q <= cnt_q + 3'd1;
				ST_EVAL: begin
					if (!tighten_q && !zero && !full) begin
						tighten_q <= 1'b1;
						border_q  <= BORDER_X_LO;
					end
				end
				ST_STEP: begin
					if (can_split) begin
						cnt_q <= '0;
					end else if (border_q != BORDER_Y_HI) begin
						border_q <= rbc_border_t'(border_q + 2'd1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					wr_row_q <= req.table_row;
					wr_col_q <= req.table_col;
					wr_val_q <= req.table_value;
					wr_ok_q  <= (req.table_row <= COORD_W'(MAX_SIDE))
					         && (req.table_col <= COORD_W'(MAX_SIDE));
					// slots in x_lo, x_hi, y_lo, y_hi order
					box_q    <= '{s_x_lo, s_x_hi, s_y_lo, s_y_hi};
					cand_q   <= '{s_x_lo, s_x_hi, s_y_lo, s_y_hi};
					acc_q   <= '0;
					act_q   <= ACT_IGNORE;
					empty_q <= bad_box;
				end
			end
			ST_RD: begin
				if (cnt_q != 3'd0) begin
					acc_q <= acc_next;
				end
				area_q <= area_full[VALUE_W-1:0];
			end
			ST_EVAL: begin
				if (!tighten_q) begin
					if (zero) begin
						act_q   <= ACT_IGNORE;
						empty_q <= 1'b1;
					end else if (full) begin
						act_q   <= ACT_INCLUDE;
						empty_q <= 1'b0;
					end
				end else if (upper) begin
					// keep the upper half while it still holds white pixels
					if (zero) begin
						w_hi_q <= mid_q;
					end else begin
						w_lo_q <= mid_q;
					end
				end else begin
					if (zero) begin
						w_lo_q <= mid_q;
					end else begin
						w_hi_q <= mid_q;
					end
				end
			end
			ST_LOAD: begin
				w_lo_q <= box_q[lo_idx];
				w_hi_q <= box_q[hi_idx];
			end
			ST_STEP: begin
				if (can_split) begin
					mid_q  <= mid;
					acc_q  <= '0;
					cand_q <= cand_d;
				end else begin
					if (upper) begin
						box_q[hi_idx] <= w_hi_q;
					end else begin
						box_q[lo_idx] <= w_lo_q;
					end
					if (border_q == BORDER_Y_HI) begin
						act_q   <= ACT_BISECT;
						empty_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/raster_box_contractor.sv =====
// channel | dir | handshake     | carries
// req     | in  | valid / ready | table write (kind 0) or box query (kind 1)
// rsp     | out | valid / ready | action, empty flag and contracted box
//
// a table write goes through the write state; a query with an empty or inverted box
// goes straight to its result, a query answered by the first white count after its four reads
// a bisect query then bisects each of the four borders in turn,
// with steps <= 8 per border at a side of 256: every white count
// needs four reads through the single port of the table memory
// arst_n clears the sequencer and the output valid; the table is not cleared
// a stalled rsp holds the result while the next item is already taken
module raster_box_contractor (
	input  logic     clk,
	input  logic     arst_n,
	rbc_req_if.sink  req,
	rbc_rsp_if.source rsp
);
	import rbc_pkg::*;

	rbc_ram_req_t           ram_req;
	logic [VALUE_W-1:0]     ram_rdata;

	// finished result from the sequencer, waiting for the output register
	rbc_result_t            res;
	logic                   res_valid;
	logic                   res_take;

	// output register, parts the sequencer from the rsp side
	rbc_result_t            out_q;
	logic                   out_valid_q;

	// sequencer: handles table writes, runs the white counts and the bisection
	rbc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// summed-area table, one entry per pixel corner
	rbc_area_ram #(
		.DEPTH  (TABLE_DEPTH),
		.WIDTH  (VALUE_W),
		.ADDR_W (ADDR_W)
	) u_area_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// result moves out when the register is free or is being emptied this cycle
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.action    = out_q.action;
	assign rsp.out_empty = out_q.empty;
	assign rsp.out_x_lo  = out_q.x_lo;
	assign rsp.out_x_hi  = out_q.x_hi;
	assign rsp.out_y_lo  = out_q.y_lo;
	assign rsp.out_y_hi  = out_q.y_hi;

endmodule

// ===== hdl/rbc_checker.sv =====
module rbc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic [1:0]                   action,
	input  logic                         out_empty,
	input  logic [rbc_pkg::COORD_W-1:0]  out_x_lo,
	input  logic [rbc_pkg::COORD_W-1:0]  out_x_hi,
	input  logic [rbc_pkg::COORD_W-1:0]  out_y_lo,
	input  logic [rbc_pkg::COORD_W-1:0]  out_y_hi
);
	import rbc_pkg::*;

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
		&& $stable({action, out_empty, out_x_lo, out_x_hi, out_y_lo, out_y_hi}))
		else $error("rsp changed while stalled");

	// ignore goes with an empty box and nothing else does
	a_ignore_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((action == ACT_IGNORE) == out_empty))
		else $error("action and empty flag disagree");

	// empty box reports zero bounds
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_empty |-> out_x_lo == '0 && out_x_hi == '0
		&& out_y_lo == '0 && out_y_hi == '0)
		else $error("empty box with nonzero bounds");

	// kept box stays ordered and inside the raster
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !out_empty |-> out_x_lo <= out_x_hi && out_y_lo <= out_y_hi
		&& out_x_hi <= COORD_W'(MAX_SIDE) && out_y_hi <= COORD_W'(MAX_SIDE))
		else $error("contracted box out of order");

endmodule

bind raster_box_contractor rbc_checker u_rbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.action    (rsp.action),
	.out_empty (rsp.out_empty),
	.out_x_lo  (rsp.out_x_lo),
	.out_x_hi  (rsp.out_x_hi),
	.out_y_lo  (rsp.out_y_lo),
	.out_y_hi  (rsp.out_y_hi)
);
